[sv/rect_fill_alpha_blend_renderer_unit_assert.svh]
// Assertion macros shared by the renderer RTL.
`ifndef RECT_FILL_ALPHA_BLEND_RENDERER_UNIT_ASSERT_SVH
`define RECT_FILL_ALPHA_BLEND_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RFAB_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rfab: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RFAB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rfab: next-cycle check failed");

`endif

[sv/rfab_pkg.sv]
// Package with shared types, constants and arithmetic helpers of the renderer.
`timescale 1ns / 1ps
package rfab_pkg;

  localparam int MaxDim  = 128;
  localparam int AddrW   = $clog2(MaxDim * MaxDim);
  localparam int DimW    = 8;
  localparam int ChW     = 16;
  localparam int PixW    = 4 * ChW;
  localparam int InDataW = 208;
  localparam logic [48:0] RoundHalf = 49'd32767;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_RECT  = 2'd1,
    MODE_POINT = 2'd2,
    MODE_READ  = 2'd3
  } rfab_mode_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } rfab_reg_e;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_SETUP, ST_RECT_CHK, ST_FILL, ST_PX_RD, ST_PX_M1,
    ST_PX_M2, ST_PX_M3, ST_PX_M4, ST_DIV_GO, ST_DIV_WAIT, ST_PX_WR, ST_RD_RD,
    ST_RESULT
  } rfab_state_e;

  typedef struct packed {
    logic take;
    logic setup;
    logic lin_clr;
    logic sweep_wr;
    logic fill_wr;
    logic px_rd;
    logic m1;
    logic m2;
    logic m3;
    logic m4;
    logic div_start;
    logic px_wr;
    logic rd_rd;
    logic res_load;
  } rfab_cmd_t;

  typedef struct packed {
    rfab_mode_e mode;
    logic       draw;
    logic       lin_top;
    logic       lin_total;
    logic       rect_last;
    logic       div_done;
  } rfab_sts_t;

  // Clamp a frame register to 1..MaxDim.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (32'(v) > MaxDim) r = DimW'(MaxDim);
    return r;
  endfunction

  // Exact floor(n / 65535) for n below 2^48 + 2^15, using 2^16 = 1 mod 65535.
  function automatic logic [31:0] div65535(input logic [48:0] n);
    logic [16:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [18:0] s;
    logic [33:0] base;
    logic [2:0]  k;
    a = n[48:32];
    b = n[31:16];
    c = n[15:0];
    s = 19'(a) + 19'(b) + 19'(c);
    base = {1'b0, a, 16'b0} + 34'(a) + 34'(b);
    k = 3'(s >= 19'd65535) + 3'(s >= 19'd131070) + 3'(s >= 19'd196605) +
        3'(s >= 19'd262140);
    return 32'(base + 34'(k));
  endfunction

endpackage

[sv/rfab_div.sv]
// Radix-2 restoring divider giving a 16-bit saturated quotient.
`timescale 1ns / 1ps
module rfab_div
  import rfab_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [32:0]       dividend_i,
  input  logic [ChW-1:0]    divisor_i,
  output logic              done_o,
  output logic [ChW-1:0]    quot_o
);

  logic [4:0]     cnt_q, cnt_d;
  logic [ChW-1:0] rem_q, rem_d;
  logic [ChW-1:0] quo_q, quo_d;
  logic [ChW-1:0] dvs_q, dvs_d;
  logic           sat_q, sat_d;
  logic           zero_q, zero_d;
  logic [ChW:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    sat_d  = sat_q;
    zero_d = zero_q;
    trial  = {rem_q, quo_q[ChW-1]};
    if (start_i) begin
      cnt_d  = 5'd16;
      dvs_d  = divisor_i;
      zero_d = (divisor_i == '0);
      // A quotient of 2^16 or more saturates; otherwise the top half is below the divisor.
      sat_d  = (dividend_i >= {1'b0, divisor_i, 16'b0});
      rem_d  = dividend_i[31:16];
      quo_d  = dividend_i[15:0];
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 5'd1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = ChW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[ChW-2:0], 1'b1};
      end else begin
        rem_d = trial[ChW-1:0];
        quo_d = {quo_q[ChW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    sat_q  <= sat_d;
    zero_q <= zero_d;
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = zero_q ? '0 : (sat_q ? '1 : quo_q);

endmodule

[sv/rfab_dp.sv]
// Datapath: command registers, clipping, framebuffer memory, blend pipe and result.
`timescale 1ns / 1ps
module rfab_dp
  import rfab_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfab_cmd_t          cmd_i,
  output rfab_sts_t          sts_o,
  input  logic [InDataW-1:0] in_data_i,
  input  logic [1:0]         in_mode_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i,
  output logic [PixW-1:0]    res_data_o,
  output logic               res_status_o
);

  logic [DimW-1:0] fw_q, fh_q;
  logic [DimW-1:0] w_eff, h_eff;
  logic [15:0]     total;

  rfab_mode_e      mode_q;
  logic [31:0]     posx_q, posy_q, sizew_q, sizeh_q;
  logic [3:0][ChW-1:0] col_q;
  logic [AddrW-1:0] ridx_q;

  assign w_eff = eff_dim(fw_q);
  assign h_eff = eff_dim(fh_q);
  assign total = w_eff * h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= DimW'(MaxDim);
      fh_q <= DimW'(MaxDim);
    end else if (cfg_we_i) begin
      if (rfab_reg_e'(cfg_idx_i) == REG_FRAME_WIDTH) fw_q <= cfg_data_i;
      else fh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q  <= rfab_mode_e'(in_mode_i);
      posx_q  <= in_data_i[31:0];
      posy_q  <= in_data_i[63:32];
      sizew_q <= in_data_i[95:64];
      sizeh_q <= in_data_i[127:96];
      col_q   <= in_data_i[191:128];
      ridx_q  <= in_data_i[205:192];
    end
  end

  // Clipping: floor by arithmetic shift, then clamp to the active frame.
  logic signed [17:0] x_s, y_s, rw_s, rh_s, x1_s, y1_s, x0c, y0c, x1c, y1c, w_s, h_s;
  logic               draw_c;

  always_comb begin
    x_s  = {{2{posx_q[31]}}, posx_q[31:16]};
    y_s  = {{2{posy_q[31]}}, posy_q[31:16]};
    rw_s = (mode_q == MODE_POINT) ? 18'sd1 : {{2{sizew_q[31]}}, sizew_q[31:16]};
    rh_s = (mode_q == MODE_POINT) ? 18'sd1 : {{2{sizeh_q[31]}}, sizeh_q[31:16]};
    w_s  = {10'b0, w_eff};
    h_s  = {10'b0, h_eff};
    x1_s = x_s + rw_s;
    y1_s = y_s + rh_s;
    x0c  = x_s[17] ? 18'sd0 : x_s;
    y0c  = y_s[17] ? 18'sd0 : y_s;
    x1c  = (x1_s > w_s) ? w_s : x1_s;
    y1c  = (y1_s > h_s) ? h_s : y1_s;
    draw_c = (rw_s > 18'sd0) && (rh_s > 18'sd0) && (x0c < x1c) && (y0c < y1c);
  end

  logic [DimW-1:0]  x0_q, x1_q, y1_q, px_q, py_q;
  logic [AddrW-1:0] rowbase_q, lin_q;
  logic             draw_q;
  logic [ChW-1:0]   inv_q;
  logic [31:0]      scsa_q [3];
  logic [15:0]      rowbase_c;

  assign rowbase_c = y0c[7:0] * w_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      x0_q      <= x0c[7:0];
      x1_q      <= x1c[7:0];
      y1_q      <= y1c[7:0];
      px_q      <= x0c[7:0];
      py_q      <= y0c[7:0];
      rowbase_q <= rowbase_c[AddrW-1:0];
      draw_q    <= draw_c;
      inv_q     <= ~col_q[3];
      for (int c = 0; c < 3; c++) scsa_q[c] <= col_q[c] * col_q[3];
    end else if (cmd_i.px_wr) begin
      if (px_q == x1_q - DimW'(1)) begin
        px_q      <= x0_q;
        py_q      <= py_q + DimW'(1);
        rowbase_q <= rowbase_q + AddrW'(w_eff);
      end else begin
        px_q <= px_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= '0;
    end else if (cmd_i.lin_clr) begin
      lin_q <= '0;
    end else if (cmd_i.sweep_wr || cmd_i.fill_wr) begin
      lin_q <= lin_q + AddrW'(1);
    end
  end

  // Framebuffer memory: one write and one registered read per cycle.
  logic [PixW-1:0]  fb_mem [MaxDim*MaxDim];
  logic [PixW-1:0]  rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr, pix_addr;
  logic [PixW-1:0]  mem_wdata, blend_px;

  assign pix_addr = rowbase_q + AddrW'(px_q);

  always_comb begin
    mem_we    = cmd_i.sweep_wr || cmd_i.fill_wr || cmd_i.px_wr;
    mem_waddr = cmd_i.px_wr ? pix_addr : lin_q;
    mem_wdata = cmd_i.sweep_wr ? '0 : (cmd_i.fill_wr ? col_q : blend_px);
    mem_re    = cmd_i.px_rd || cmd_i.rd_rd;
    mem_raddr = cmd_i.rd_rd ? ridx_q : pix_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) fb_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= fb_mem[mem_raddr];
  end

  // Blend pipe.
  logic [31:0]    dainv_q;
  logic [31:0]    dcda_q [3];
  logic [47:0]    qp_q [3];
  logic [31:0]    t_q [3];
  logic [32:0]    acc_q [3];
  logic [ChW-1:0] oa_q;
  logic [31:0]    dv_a;
  logic [16:0]    oa_sum;
  logic [ChW-1:0] da;

  assign da     = rdata_q[63:48];
  assign dv_a   = div65535({17'b0, dainv_q} + RoundHalf);
  assign oa_sum = 17'(col_q[3]) + 17'(dv_a[15:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.m1) begin
      dainv_q <= da * inv_q;
      for (int c = 0; c < 3; c++) dcda_q[c] <= rdata_q[16*c +: 16] * da;
    end
    if (cmd_i.m2) begin
      oa_q <= oa_sum[16] ? '1 : oa_sum[15:0];
      for (int c = 0; c < 3; c++) qp_q[c] <= dcda_q[c] * inv_q;
    end
    if (cmd_i.m3) begin
      for (int c = 0; c < 3; c++) t_q[c] <= div65535({1'b0, qp_q[c]} + RoundHalf);
    end
    if (cmd_i.m4) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= 33'(scsa_q[c]) + 33'(t_q[c]) + 33'(oa_q[15:1]);
      end
    end
  end

  logic [2:0]     div_done;
  logic [ChW-1:0] quot [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    rfab_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (acc_q[c]),
      .divisor_i  (oa_q),
      .done_o     (div_done[c]),
      .quot_o     (quot[c])
    );
  end

  assign blend_px = {oa_q, quot[2], quot[1], quot[0]};

  // Result register.
  logic oob;
  assign oob = ({2'b0, ridx_q} >= total);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (mode_q == MODE_READ) begin
        res_status_o <= oob;
        res_data_o   <= oob ? '0 : rdata_q;
      end else begin
        res_status_o <= 1'b0;
        res_data_o   <= '0;
      end
    end
  end

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.draw      = draw_q;
    sts_o.lin_top   = (lin_q == '1);
    sts_o.lin_total = ({2'b0, lin_q} == total - 16'd1);
    sts_o.rect_last = (px_q == x1_q - DimW'(1)) && (py_q == y1_q - DimW'(1));
    sts_o.div_done  = &div_done;
  end

endmodule

[sv/rfab_ctrl.sv]
// Controller state machine sequencing sweep, fill, per-pixel blend and read.
`timescale 1ns / 1ps
module rfab_ctrl
  import rfab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rfab_sts_t sts_i,
  output rfab_cmd_t cmd_o
);

  rfab_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.lin_top) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup   = 1'b1;
        cmd_o.lin_clr = 1'b1;
        case (sts_i.mode)
          MODE_CLEAR: state_d = ST_FILL;
          MODE_READ:  state_d = ST_RD_RD;
          default:    state_d = ST_RECT_CHK;
        endcase
      end
      ST_RECT_CHK: state_d = sts_i.draw ? ST_PX_RD : ST_RESULT;
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.lin_total) state_d = ST_RESULT;
      end
      ST_PX_RD: begin
        cmd_o.px_rd = 1'b1;
        state_d     = ST_PX_M1;
      end
      ST_PX_M1: begin
        cmd_o.m1 = 1'b1;
        state_d  = ST_PX_M2;
      end
      ST_PX_M2: begin
        cmd_o.m2 = 1'b1;
        state_d  = ST_PX_M3;
      end
      ST_PX_M3: begin
        cmd_o.m3 = 1'b1;
        state_d  = ST_PX_M4;
      end
      ST_PX_M4: begin
        cmd_o.m4 = 1'b1;
        state_d  = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (sts_i.div_done) state_d = ST_PX_WR;
      ST_PX_WR: begin
        cmd_o.px_wr = 1'b1;
        state_d     = sts_i.rect_last ? ST_RESULT : ST_PX_RD;
      end
      ST_RD_RD: begin
        cmd_o.rd_rd = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/rect_fill_alpha_blend_renderer_unit.sv]
// Top level of the rectangle-fill, source-over blending framebuffer renderer.
//
// The slave stream takes one command per beat: tuser carries the mode (clear,
// rectangle, point, read) and tdata the position, size, color and read index.
// Every command returns exactly one beat on the master stream: tuser is the
// status bit (set for a read outside the active frame) and tdata the read
// pixel, or zeros for anything but a successful read.
// The frame size comes from two registers on the plain write port, which are to be
// written only while the block is idle; the block itself does not enforce this.
// One command is worked at a time. A clear writes its color to each of the
// width*height pixels in turn. A rectangle or point works each covered pixel in
// turn through the per-pixel read, the multiply pipe and the 16-step iterative divide that
// normalizes each color channel by the new alpha; an empty one goes to the result.
// A read fetches the indexed pixel from the framebuffer memory.
// After reset the block sweeps the whole 16384-entry framebuffer to zero, one
// entry per cycle, with tready low; configuration writes are taken meanwhile.
// The result sits in an output register, so the next command is accepted while
// a result waits; if the receiver stalls, the following result is held back
// in the controller until the output register frees up.
`timescale 1ns / 1ps
`include "rect_fill_alpha_blend_renderer_unit_assert.svh"
module rect_fill_alpha_blend_renderer_unit
  import rfab_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // pos_x_q16, pos_y_q16, size_w_q16, size_h_q16, src_red, src_green,
  // src_blue, src_alpha, read_index, two zero bits
  input  logic [InDataW-1:0] s_axis_tdata,
  // mode
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // pix_red, pix_green, pix_blue, pix_alpha
  output logic [PixW-1:0]    m_axis_tdata,
  // status
  output logic [0:0]         m_axis_tuser,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i
);

  rfab_cmd_t cmd;
  rfab_sts_t sts;

  // Sequencer: owns the handshakes and drives the datapath one step at a time.
  rfab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: framebuffer memory, clipping, blend pipe, dividers and result.
  rfab_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .in_mode_i    (s_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .res_data_o   (m_axis_tdata),
    .res_status_o (m_axis_tuser[0])
  );

  // A command is taken only when the previous one has fully finished.
  `RFAB_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A new result never overwrites one the receiver has not taken.
  `RFAB_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd.res_load, !m_axis_tvalid || m_axis_tready)
  // Starting a divide clears the done flag on the following cycle.
  `RFAB_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, cmd.div_start, !sts.div_done)
  // The clearing sweep never overlaps the input handshake.
  `RFAB_ASSERT_IMP(a_sweep_blocks, clk_i, rst_ni, cmd.sweep_wr, !s_axis_tready)

endmodule
